FILE: rtl/rsp_pkg.sv
// Package for the ramp/soak setpoint generator: sizes, FSM state codes, result struct.
// No dependencies; imported by ramp_soak_profile_generator and the testbench.
package rsp_pkg;

  localparam int NUM_POINTS = 6;
  localparam int VALUE_BITS = 16;
  localparam int TIME_BITS  = 17;
  localparam int POINT_W    = TIME_BITS + VALUE_BITS;
  localparam int PT_IDX_W   = $clog2(NUM_POINTS);
  localparam int SEC_W      = 32;
  // part (unsigned) times value difference (signed, one bit wider than a value)
  localparam int PROD_W     = TIME_BITS + VALUE_BITS + 2;
  // magnitude of that product stays below 2**(TIME_BITS+VALUE_BITS)
  localparam int MAG_W      = TIME_BITS + VALUE_BITS;
  localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

  localparam int IN_USER_W  = 3;
  localparam int IN_DATA_W  = SEC_W;
  localparam int OUT_USER_W = 2;
  localparam int OUT_DATA_W = VALUE_BITS + SEC_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_MULT = 8'b0000_1000,
    S_NORM = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIX  = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic                         done;
    logic                         busy;
    logic [SEC_W-1:0]             elapsed;
    logic signed [VALUE_BITS-1:0] setpoint;
  } res_t;

endpackage

FILE: rtl/ramp_soak_profile_generator.sv
// Ramp/soak setpoint generator: breakpoint registers, run control, scan and serial divider.
// Depends on rsp_pkg.
//
//  channel  | direction | transaction
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser {stop,pause,start}, tdata now_seconds
//  m_axis   | out       | tuser {done,busy}, tdata {elapsed_out,setpoint}
//  cfg      | in        | cfg_index_i selects point_k, cfg_data_i is written
//
// A result passes through S_EXEC and S_EMIT for stop, pause and idle commands; a running
// call that reaches the end time also passes S_SCAN (one scan cycle per breakpoint), and
// an interpolation adds S_MULT, S_NORM, the one-bit-per-cycle divider S_DIV (MAG_W steps)
// and S_FIX. The input is ready again in the same cycle that the result is offered. Reset
// clears breakpoints and run state. A stalled output holds the FSM in S_EMIT with
// s_axis_tready low until the output register frees.
module ramp_soak_profile_generator
  import rsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [31:0] now_seconds
  input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [0] start_req, [1] pause_req, [2] stop_req
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [15:0] setpoint, [47:16] elapsed_out
  output logic [OUT_USER_W-1:0] m_axis_tuser,  // [0] busy_res, [1] done_res
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [PT_IDX_W-1:0]   cfg_index_i,
  input  logic [POINT_W-1:0]    cfg_data_i
);

  state_e                       state_q;
  logic [POINT_W-1:0]           point_q [NUM_POINTS];
  logic                         running_q, init_q, out_valid_q;
  logic [SEC_W-1:0]             elapsed_q, prev_q;

  logic                         start_q, pause_q, stop_q;
  logic [SEC_W-1:0]             now_q, step_q;
  logic [PT_IDX_W-1:0]          k_q;
  logic                         found_q;
  logic [TIME_BITS-1:0]         tprev_q, part_q, span_q;
  logic signed [VALUE_BITS-1:0] vprev_q, v0_q;
  logic signed [VALUE_BITS:0]   diff_q;
  logic signed [PROD_W-1:0]     prod_q;
  logic                         neg_q;
  logic [TIME_BITS-1:0]         rem_q;
  logic [MAG_W-1:0]             quo_q;
  logic [DIV_CNT_W-1:0]         cnt_q;
  res_t                         res_q, out_q;

  logic [SEC_W:0]               elapsed_sum;
  logic [SEC_W-1:0]             elapsed_new;
  logic                         first_start, run_now;
  logic [POINT_W-1:0]           cur_pt;
  logic [TIME_BITS-1:0]         t_raw, t_fix;
  logic signed [VALUE_BITS-1:0] v_cur, v_first;
  logic                         hit, last_pt;
  logic [TIME_BITS:0]           rem_shift;
  logic                         rem_ge;
  logic [PROD_W-1:0]            prod_abs;
  logic [VALUE_BITS-1:0]        q_lo;
  logic                         out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.elapsed, out_q.setpoint};
  assign m_axis_tuser  = {out_q.done, out_q.busy};
  assign out_free      = !out_valid_q || m_axis_tready;

  // run bookkeeping
  assign first_start = start_q && !init_q;
  assign run_now     = running_q || start_q;
  assign elapsed_sum = {1'b0, elapsed_q} + {1'b0, step_q};
  assign elapsed_new = first_start ? '0 :
                       (elapsed_sum[SEC_W] ? '1 : elapsed_sum[SEC_W-1:0]);

  // breakpoint scan, one point per cycle; times forced non-decreasing
  assign cur_pt  = point_q[k_q];
  assign t_raw   = cur_pt[POINT_W-1:VALUE_BITS];
  assign v_cur   = cur_pt[VALUE_BITS-1:0];
  assign v_first = point_q[0][VALUE_BITS-1:0];
  assign t_fix   = (t_raw < tprev_q) ? tprev_q : t_raw;
  assign hit     = !found_q && (elapsed_q < {{(SEC_W-TIME_BITS){1'b0}}, t_fix});
  assign last_pt = (k_q == PT_IDX_W'(NUM_POINTS - 1));

  // restoring divider step
  assign rem_shift = {rem_q, quo_q[MAG_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, span_q};
  assign prod_abs  = prod_q[PROD_W-1] ? (-prod_q) : prod_q;
  assign q_lo      = quo_q[VALUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        point_q[i] <= '0;
      end
    end else if (cfg_valid_i && (int'(cfg_index_i) < NUM_POINTS)) begin
      point_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      running_q   <= 1'b0;
      init_q      <= 1'b0;
      elapsed_q   <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // S_EMIT handles the output register itself
      if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (stop_q) begin
            running_q <= 1'b0;
            init_q    <= 1'b0;
            elapsed_q <= '0;
            state_q   <= S_EMIT;
          end else if (pause_q) begin
            running_q <= 1'b0;
            state_q   <= S_EMIT;
          end else if (run_now) begin
            running_q <= 1'b1;
            init_q    <= 1'b1;
            elapsed_q <= elapsed_new;
            prev_q    <= now_q;
            state_q   <= S_SCAN;
          end else begin
            prev_q  <= now_q;
            state_q <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (last_pt) begin
            if (found_q || hit) begin
              state_q <= S_MULT;
            end else begin
              running_q <= 1'b0;
              state_q   <= S_EMIT;
            end
          end
        end
        S_MULT: state_q <= S_NORM;
        S_NORM: state_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == DIV_CNT_W'(MAG_W - 1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        start_q <= s_axis_tuser[0];
        pause_q <= s_axis_tuser[1];
        stop_q  <= s_axis_tuser[2];
        now_q   <= s_axis_tdata;
        step_q  <= (s_axis_tdata > prev_q) ? (s_axis_tdata - prev_q) : '0;
      end
      S_EXEC: begin
        res_q.done     <= 1'b0;
        res_q.busy     <= 1'b0;
        res_q.setpoint <= '0;
        res_q.elapsed  <= (!stop_q && pause_q) ? elapsed_q : '0;
        k_q     <= '0;
        found_q <= 1'b0;
        tprev_q <= '0;
        vprev_q <= v_first;
      end
      S_SCAN: begin
        if (hit) begin
          found_q <= 1'b1;
          part_q  <= elapsed_q[TIME_BITS-1:0] - tprev_q;
          span_q  <= t_fix - tprev_q;
          diff_q  <= {v_cur[VALUE_BITS-1], v_cur} - {vprev_q[VALUE_BITS-1], vprev_q};
          v0_q    <= vprev_q;
        end
        tprev_q <= t_fix;
        vprev_q <= v_cur;
        k_q     <= k_q + 1'b1;
        if (last_pt) begin
          if (found_q || hit) begin
            res_q.busy    <= 1'b1;
            res_q.elapsed <= elapsed_q;
          end else begin
            res_q.done     <= 1'b1;
            res_q.elapsed  <= {{(SEC_W-TIME_BITS){1'b0}}, t_fix};
            res_q.setpoint <= v_cur;
          end
        end
      end
      S_MULT: begin
        prod_q <= $signed({1'b0, part_q}) * diff_q;
      end
      S_NORM: begin
        neg_q <= prod_q[PROD_W-1];
        rem_q <= '0;
        quo_q <= prod_abs[MAG_W-1:0];
        cnt_q <= '0;
      end
      S_DIV: begin
        rem_q <= rem_ge ? TIME_BITS'(rem_shift - {1'b0, span_q}) : rem_shift[TIME_BITS-1:0];
        quo_q <= {quo_q[MAG_W-2:0], rem_ge};
        cnt_q <= cnt_q + 1'b1;
      end
      S_FIX: begin
        res_q.setpoint <= neg_q ? (v0_q - $signed(q_lo)) : (v0_q + $signed(q_lo));
      end
      S_EMIT: begin
        if (out_free) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  a_run_needs_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> init_q) else $error("running without initialization");

  a_uninit_elapsed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |-> (elapsed_q == '0)) else $error("elapsed nonzero before first start");

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.busy && out_q.done)) else $error("busy and done together");

  a_div_span_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (span_q != '0)) else $error("divide by zero span");

  a_div_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < DIV_CNT_W'(MAG_W))) else $error("divider overran");

endmodule

FILE: verif/tb.sv
// Testbench for ramp_soak_profile_generator: writes breakpoint profiles, sends start/pause/stop
// commands with time stamps and checks every result against an in-bench profile predictor.
// Depends on rsp_pkg and the ramp_soak_profile_generator RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rsp_pkg::*;

  localparam int START_BIT = 0;
  localparam int PAUSE_BIT = 1;
  localparam int STOP_BIT  = 2;
  localparam logic [IN_USER_W-1:0] CMD_NONE  = '0;
  localparam logic [IN_USER_W-1:0] CMD_START = 1 << START_BIT;
  localparam logic [IN_USER_W-1:0] CMD_PAUSE = 1 << PAUSE_BIT;
  localparam logic [IN_USER_W-1:0] CMD_STOP  = 1 << STOP_BIT;

  localparam int TIME_MAX = (1 << TIME_BITS) - 1;
  localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  localparam int ITEM_TARGET  = 1450;
  localparam int IDLE_PCT     = 32;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_PRINTS   = 50;

  typedef enum int {PROFILE_RAMP, PROFILE_SCATTER, PROFILE_EXTREME} profile_shape_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [PT_IDX_W-1:0]   cfg_index_i = '0;
  logic [POINT_W-1:0]    cfg_data_i = '0;

  // predictor state
  logic [POINT_W-1:0] breakpoints [NUM_POINTS] = '{default: '0};
  logic               profile_running = 1'b0;
  logic               profile_armed = 1'b0;
  logic [SEC_W-1:0]   elapsed_s = '0;
  logic [SEC_W-1:0]   last_now_s = '0;
  res_t               profile_results_q [$];

  int err_cnt = 0;
  int items_sent = 0;
  int cycle_cnt = 0;
  bit no_stall = 1'b0;

  ramp_soak_profile_generator u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) m_axis_tready <= no_stall || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [SEC_W-1:0] bp_time(int k);
    return SEC_W'(breakpoints[k][POINT_W-1:VALUE_BITS]);
  endfunction

  function automatic longint bp_value(int k);
    return longint'($signed(breakpoints[k][VALUE_BITS-1:0]));
  endfunction

  function automatic logic [SEC_W-1:0] profile_end();
    logic [SEC_W-1:0] t_max;
    int k;
    t_max = '0;
    for (k = 0; k < NUM_POINTS; k++)
      if (bp_time(k) > t_max) t_max = bp_time(k);
    return t_max;
  endfunction

  // breakpoint times are clamped to be non-decreasing; zero-length segments fall through
  function automatic longint interpolate(logic [SEC_W-1:0] at);
    logic [SEC_W-1:0] t_prev, t;
    longint v_prev, v;
    int k;
    t_prev = '0;
    v_prev = bp_value(0);
    for (k = 0; k < NUM_POINTS; k++) begin
      t = bp_time(k);
      v = bp_value(k);
      if (t < t_prev) t = t_prev;
      if (at < t)
        return v_prev + (longint'(at - t_prev) * (v - v_prev)) / longint'(t - t_prev);
      t_prev = t;
      v_prev = v;
    end
    return v_prev;
  endfunction

  function automatic res_t advance_profile(logic [IN_USER_W-1:0] cmd, logic [SEC_W-1:0] now);
    res_t r;
    logic [SEC_W-1:0] step, t_end;
    longint sp;
    r = '0;
    sp = 0;
    if (cmd[STOP_BIT]) begin
      profile_running = 1'b0;
      profile_armed = 1'b0;
      elapsed_s = '0;
    end else if (cmd[PAUSE_BIT]) begin
      profile_running = 1'b0;
      r.elapsed = elapsed_s;
    end else begin
      if (cmd[START_BIT]) begin
        profile_running = 1'b1;
        if (!profile_armed) begin
          elapsed_s = '0;
          last_now_s = now;
          profile_armed = 1'b1;
        end
      end
      if (profile_running) begin
        step = (now > last_now_s) ? now - last_now_s : '0;
        if (step > ~elapsed_s) elapsed_s = '1;
        else elapsed_s += step;
        last_now_s = now;
        t_end = profile_end();
        if (elapsed_s >= t_end) begin
          r.done = 1'b1;
          sp = interpolate(t_end);
          r.elapsed = t_end;
          profile_running = 1'b0;
        end else begin
          r.busy = 1'b1;
          sp = interpolate(elapsed_s);
          r.elapsed = elapsed_s;
        end
      end else begin
        last_now_s = now;
      end
    end
    r.setpoint = sp[VALUE_BITS-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_result(res_t got);
    res_t want;
    if (profile_results_q.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(got), '0);
      return;
    end
    want = profile_results_q.pop_front();
    if (got.setpoint !== want.setpoint)
      report_mismatch("setpoint", 64'(got.setpoint), 64'(want.setpoint));
    if (got.elapsed !== want.elapsed)
      report_mismatch("elapsed", 64'(got.elapsed), 64'(want.elapsed));
    if (got.busy !== want.busy) report_mismatch("busy", 64'(got.busy), 64'(want.busy));
    if (got.done !== want.done) report_mismatch("done", 64'(got.done), 64'(want.done));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(res_t'({m_axis_tuser, m_axis_tdata}));
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_POINTS)
        breakpoints[cfg_index_i] = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        profile_results_q.push_back(advance_profile(s_axis_tuser, s_axis_tdata));
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_cmd(logic [IN_USER_W-1:0] cmd, logic [SEC_W-1:0] now);
    while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_point(logic [PT_IDX_W-1:0] idx, logic [POINT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [POINT_W-1:0] pack_point(logic [TIME_BITS-1:0] t,
                                                   logic [VALUE_BITS-1:0] v);
    return {t, v};
  endfunction

  // sender holds off until every pending transaction has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (profile_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_reset_state();
    send_cmd(CMD_NONE, '0);
    send_cmd(CMD_START, '1);  // all end times zero: done at once
    send_cmd(CMD_NONE, '1);
  endtask

  task automatic test_command_priority();
    drain_results();
    write_point(0, pack_point(0, VALUE_MIN));
    write_point(1, pack_point(40, VALUE_MAX));
    write_point(2, pack_point(40, 100));     // zero-length segment
    write_point(3, pack_point(25, -50));     // earlier than point 2
    write_point(4, pack_point(100, 0));
    write_point(5, pack_point(200, '1));
    send_cmd(CMD_STOP | CMD_PAUSE | CMD_START, 5);
    send_cmd(CMD_PAUSE | CMD_START, 6);
    send_cmd(CMD_STOP | CMD_START, 7);
    send_cmd(CMD_START, 1000);
    send_cmd(CMD_NONE, 1020);
    send_cmd(CMD_NONE, 1010);                // time runs backwards
    send_cmd(CMD_PAUSE, 1500);
    send_cmd(CMD_NONE, 1600);
    send_cmd(CMD_START, 1630);
    send_cmd(CMD_START, 1700);
    send_cmd(CMD_NONE, 2000);
  endtask

  task automatic test_elapsed_saturation();
    drain_results();
    write_point(4, '1);
    write_point(5, pack_point(TIME_MAX, 7));
    write_point(NUM_POINTS, '1);
    write_point(NUM_POINTS + 1, '1);
    send_cmd(CMD_STOP, '0);
    send_cmd(CMD_START, '0);
    send_cmd(CMD_NONE, '1);
    send_cmd(CMD_NONE, '0);
    send_cmd(CMD_START, 16);                 // armed run resumes past the end, saturates
    send_cmd(CMD_PAUSE, 3);
  endtask

  task automatic load_random_profile(profile_shape_e shape);
    logic [TIME_BITS-1:0]  t_acc, t;
    logic [VALUE_BITS-1:0] v;
    int k;
    t_acc = '0;
    for (k = 0; k < NUM_POINTS; k++) begin
      case (shape)
        PROFILE_RAMP: begin
          t_acc += TIME_BITS'($urandom_range(60));
          t = t_acc;
        end
        PROFILE_SCATTER: t = TIME_BITS'($urandom_range(TIME_MAX));
        default:         t = $urandom_range(1) ? TIME_BITS'(TIME_MAX) : '0;
      endcase
      case ($urandom_range(9))
        0:       v = VALUE_MIN;
        1:       v = VALUE_MAX;
        default: v = VALUE_BITS'($urandom);
      endcase
      write_point(PT_IDX_W'(k), pack_point(t, v));
    end
    if ($urandom_range(3) == 0)
      write_point(PT_IDX_W'(NUM_POINTS + $urandom_range(1)),
                  POINT_W'({$urandom_range(1), $urandom}));
  endtask

  // mostly stop, then start, then advance with mostly forward time steps until the run ends or 40 steps are done
  task automatic run_sequence(logic [SEC_W-1:0] end_t);
    logic [SEC_W-1:0] now;
    int n, r, step_max;
    step_max = end_t / 6 + 2;
    now = $urandom;
    if ($urandom_range(9) < 7) send_cmd(CMD_STOP, $urandom);
    else send_cmd(CMD_NONE, $urandom);
    send_cmd(CMD_START, now);
    for (n = 0; n < 40 && profile_running; n++) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_cmd(CMD_PAUSE, now + $urandom_range(100));
        now += $urandom_range(step_max);
        send_cmd(CMD_START, now);
      end else if (r < 10) begin
        now -= $urandom_range(50);
        send_cmd(CMD_NONE, now);
      end else if (r < 13) begin
        now += $urandom;
        send_cmd(CMD_NONE, now);
      end else if (r < 16) begin
        send_cmd(IN_USER_W'($urandom_range(7)), $urandom);
      end else begin
        now += $urandom_range(step_max);
        send_cmd((r < 30) ? CMD_START : CMD_NONE, now);
      end
    end
    if ($urandom_range(1)) send_cmd(IN_USER_W'($urandom_range(7)), $urandom);
  endtask

  task automatic test_random_profiles();
    int profile, first_item;
    profile_shape_e shape;
    profile = 0;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      no_stall = (profile == 3);
      case ($urandom_range(9))
        0, 1:    shape = PROFILE_EXTREME;
        2, 3, 4: shape = PROFILE_SCATTER;
        default: shape = PROFILE_RAMP;
      endcase
      if (profile == 1) shape = PROFILE_EXTREME;
      load_random_profile(shape);
      first_item = items_sent;
      while (items_sent - first_item < 110 && items_sent < ITEM_TARGET)
        run_sequence(profile_end());
      profile++;
    end
    no_stall = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_command_priority();
    test_elapsed_saturation();
    test_random_profiles();
    drain_results();
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
